// ===== hdl/sorted_priority_queue_top_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define SPQ_ASSERT_IMPLIES(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("assertion failed");
// next-cycle implication
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("assertion failed");
`else
`define SPQ_ASSERT_IMPLIES(label, clk, rst, cond, expr)
`define SPQ_ASSERT_NEXT(label, clk, rst, cond, expr)
`endif

`endif

// ===== hdl/spq_pkg.sv =====
`default_nettype none
package spq_pkg;

   localparam int DEPTH   = 16;
   localparam int VALUE_W = 32;
   localparam int COUNT_W = 5;
   localparam int RSP_W   = 40;

   typedef logic [VALUE_W-1:0] value_type;
   typedef logic [COUNT_W-1:0] count_type;

   typedef enum logic {
      OP_PUSH = 1'b0,
      OP_POP  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   // broadcast to every cell
   typedef struct packed {
      logic      push;
      logic      pop;
      value_type value;
   } cell_cmd_type;

   typedef struct packed {
      count_type  count;
      value_type  out_value;
      status_type status;
   } rsp_type;

endpackage
`default_nettype wire

// ===== hdl/spq_cell.sv =====
`default_nettype none
module spq_cell
   import spq_pkg::*;
(
   input  wire logic         clock,
   input  wire cell_cmd_type cmd,
   input  wire logic         occupied,   // this slot is below the fill count
   input  wire logic         left_gt,    // left neighbor keeps its entry on push
   input  wire value_type    left_val,
   input  wire value_type    right_val,
   output logic              gt,         // this entry is strictly above the pushed value
   output value_type         val
);

   value_type val_ff;
   value_type val_in;

   assign gt  = occupied && ($signed(val_ff) > $signed(cmd.value));
   assign val = val_ff;

   always_comb begin
      val_in = val_ff;
      if (cmd.pop) begin
         val_in = right_val;
      end else if (cmd.push) begin
         if (gt) begin
            val_in = val_ff;
         end else if (left_gt) begin
            val_in = cmd.value;         // insertion point
         end else begin
            val_in = left_val;          // shift down
         end
      end
   end

   always_ff @(posedge clock) begin
      val_ff <= val_in;
   end

endmodule
`default_nettype wire

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted max-priority queue, one push or pop request per clock while the rsp side is not stalled.
// A result is registered and appears on the rsp side in the cycle after its request is taken.
// Throughput: one request per cycle unless rsp_tready holds off; every cell compares and shifts in parallel.
// Reset (synchronous, active high) empties the queue and drops a pending result;
// stored entries are not cleared, only the fill count.
`default_nettype none
`include "sorted_priority_queue_top_macros.svh"
module sorted_priority_queue_top
   import spq_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [VALUE_W-1:0] req_tdata,   // [31:0] value
   input  wire logic               req_tuser,   // [0] op (0 push, 1 pop)
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [RSP_W-1:0]        rsp_tdata    // [1:0] status, [33:2] out_value,
                                                // [38:34] count, [39] zero
);

   // control
   count_type    fill_ff;
   count_type    fill_in;
   logic         rsp_valid_ff;
   logic         rsp_valid_in;
   rsp_type      rsp_data_ff;
   rsp_type      rsp_data_in;

   logic         accept;
   logic         is_pop;
   logic         full;
   logic         empty;
   logic         push_ok;
   logic         pop_ok;
   cell_cmd_type cmd;

   // cell chain
   logic      [DEPTH-1:0] cell_gt;
   value_type             cell_val [DEPTH];

   // Output register frees up when it is empty or drained this cycle.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign is_pop     = (req_tuser == OP_POP);
   assign full       = (fill_ff == COUNT_W'(DEPTH));
   assign empty      = (fill_ff == '0);
   // rejected requests leave the cells and the count alone
   assign push_ok    = accept && !is_pop && !full;
   assign pop_ok     = accept && is_pop && !empty;

   assign cmd.push  = push_ok;
   assign cmd.pop   = pop_ok;
   assign cmd.value = req_tdata;

   // Each cell sees its left neighbor (value and keep flag) for push and its
   // right neighbor for pop. Cell 0 has a virtual left neighbor that always
   // keeps, so a value not below cell 0 lands there.
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_gt;
      value_type left_val;
      value_type right_val;

      if (i == 0) begin : g_head
         assign left_gt  = 1'b1;
         assign left_val = '0;
      end else begin : g_body
         assign left_gt  = cell_gt[i-1];
         assign left_val = cell_val[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_val = '0;
      end else begin : g_inner
         assign right_val = cell_val[i+1];
      end

      spq_cell u_cell (
         .clock     (clock),
         .cmd       (cmd),
         .occupied  (COUNT_W'(i) < fill_ff),
         .left_gt   (left_gt),
         .left_val  (left_val),
         .right_val (right_val),
         .gt        (cell_gt[i]),
         .val       (cell_val[i])
      );
   end

   always_comb begin
      fill_in = fill_ff;
      if (push_ok) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_ok) begin
         fill_in = fill_ff - 1'b1;
      end

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in.status    = STATUS_OK;
      if (accept && !is_pop && full) begin
         rsp_data_in.status = STATUS_FULL;
      end else if (accept && is_pop && empty) begin
         rsp_data_in.status = STATUS_EMPTY;
      end
      rsp_data_in.out_value = pop_ok ? cell_val[0] : '0;
      rsp_data_in.count     = fill_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // checks
   `SPQ_ASSERT_IMPLIES(a_fill_bound, clock, reset, 1'b1, fill_ff <= COUNT_W'(DEPTH))
   `SPQ_ASSERT_NEXT(a_push_grows, clock, reset, push_ok, fill_ff == $past(fill_ff) + 1'b1)
   `SPQ_ASSERT_NEXT(a_reject_holds, clock, reset, accept && !push_ok && !pop_ok, fill_ff == $past(fill_ff))
   `SPQ_ASSERT_NEXT(a_pop_head, clock, reset, pop_ok, rsp_data_ff.out_value == $past(cell_val[0]))

endmodule
`default_nettype wire
